### design/spc_pkg.sv
// spc_pkg: shared types and constants for the skin pixel classifier.
// Beat structs, pipeline stage map, hue sector coding. No dependencies.
`default_nettype none

package spc_pkg;

    // pipeline stage map: input reg, color front, prep, divider, output reg
    localparam int FRONT_STG = 3;
    localparam int DIV_STG   = 6;
    localparam int STG_IN    = 0;
    localparam int STG_FRONT = STG_IN + 1;
    localparam int STG_PREP  = STG_FRONT + FRONT_STG;
    localparam int STG_DIV   = STG_PREP + 1;
    localparam int STG_OUT   = STG_DIV + DIV_STG;
    localparam int N_STG     = STG_OUT + 1;

    // hue numerator is |diff| * 60, at most 255 * 60
    localparam int NUM_W     = 14;
    localparam int HUE_SCALE = 60;

    localparam logic [8:0] HUE_BASE_RED   = 9'd0;
    localparam logic [8:0] HUE_BASE_GREEN = 9'd120;
    localparam logic [8:0] HUE_BASE_BLUE  = 9'd240;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_pix_in;

    typedef struct packed {
        logic       is_skin;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [8:0] hue_deg;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // what rides along with the divider
    typedef struct packed {
        t_rgb    rgb;
        t_sector sector;
        logic    pre_skin;
    } t_side;

    function automatic logic [8:0] sector_base(input t_sector sec);
        logic [8:0] base;
        unique case (sec)
            SEC_RED:   base = HUE_BASE_RED;
            SEC_GREEN: base = HUE_BASE_GREEN;
            SEC_BLUE:  base = HUE_BASE_BLUE;
            default:   base = HUE_BASE_RED;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

### design/skin_pixel_classifier.sv
// skin_pixel_classifier: top level with per-stage flow control and the result register.
// Uses spc_pkg, spc_front, spc_prep and spc_div.
`default_nettype none

// Takes one YCbCr pixel per beat and returns one result beat per pixel, in order:
// clamped RGB, hue in degrees and a skin flag. Sustained rate is one pixel per clock
// while the result side does not stall. A beat lands in the input register, then
// passes three conversion stages (constant products, clamp, reciprocal multiply),
// one max/min and rule stage, six stages of the restoring hue divider (one quotient
// bit each) and the result register. Every stage holds its own valid bit, so a
// stall on the result side only backs up as far as the pipeline is full; empty
// slots still take new pixels.
module skin_pixel_classifier (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire spc_pkg::t_pix_in    i_pix,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output spc_pkg::t_pix_out        o_pix
);
    import spc_pkg::*;

    localparam logic [8:0] HUE_LOW  = 9'd36;
    localparam logic [8:0] HUE_HIGH = 9'd324;

    logic [N_STG-1:0]   r_vld;
    logic [N_STG-1:0]   en;
    t_pix_in            r_in;
    t_pix_out           r_out;
    t_pix_out           n_out;

    t_rgb               front_rgb;
    logic               front_chroma;
    logic [NUM_W-1:0]   prep_num;
    logic [7:0]         prep_den;
    t_side              prep_side;
    logic [DIV_STG-1:0] div_quo;
    t_side              div_side;
    logic [8:0]         hue;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        en[N_STG-1] = !r_vld[N_STG-1] || !i_stall;
        for (int k = N_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[STG_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[STG_IN]) begin
                r_vld[STG_IN] <= i_valid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_IN]) begin
            r_in <= i_pix;
        end
    end

    spc_front u_front (
        .i_clk       (i_clk),
        .i_en        (en[STG_FRONT +: FRONT_STG]),
        .i_pix       (r_in),
        .o_rgb       (front_rgb),
        .o_chroma_ok (front_chroma)
    );

    spc_prep u_prep (
        .i_clk       (i_clk),
        .i_en        (en[STG_PREP]),
        .i_rgb       (front_rgb),
        .i_chroma_ok (front_chroma),
        .o_num       (prep_num),
        .o_den       (prep_den),
        .o_side      (prep_side)
    );

    spc_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[STG_DIV +: DIV_STG]),
        .i_num  (prep_num),
        .i_den  (prep_den),
        .i_side (prep_side),
        .o_quo  (div_quo),
        .o_side (div_side)
    );

    always_comb begin
        hue             = sector_base(div_side.sector) + 9'(div_quo);
        n_out.is_skin   = div_side.pre_skin && ((hue < HUE_LOW) || (hue > HUE_HIGH));
        n_out.red_out   = div_side.rgb.r;
        n_out.green_out = div_side.rgb.g;
        n_out.blue_out  = div_side.rgb.b;
        n_out.hue_deg   = hue;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[STG_OUT];
    assign o_pix   = r_out;

endmodule

`default_nettype wire

### design/spc_front.sv
// spc_front: YCbCr to RGB conversion and Cr-versus-Cb bound checks, three stages.
// Uses spc_pkg types; stage enables come from the top-level flow control.
`default_nettype none

module spc_front (
    input  wire logic                   i_clk,
    input  wire logic [2:0]             i_en,
    input  wire spc_pkg::t_pix_in       i_pix,
    output spc_pkg::t_rgb               o_rgb,
    output logic                        o_chroma_ok
);
    import spc_pkg::*;

    localparam int K_Y       = 10000;
    localparam int K_R_CR    = 13711;
    localparam int K_G_CB    = 3369;
    localparam int K_G_CR    = 6892;
    localparam int K_B_CB    = 17324;
    localparam int CLAMP_TOP = 2550000;
    // floor(s / 10000) == (s * RECIP) >> RECIP_SH for 0 <= s <= CLAMP_TOP
    localparam int RECIP     = 1717987;
    localparam int RECIP_SH  = 34;

    localparam int K_CR      = 10000;
    localparam int B1_SLOPE  = 15000;
    localparam int B1_OFS    = 200000;
    localparam int B2_SLOPE  = 3400;
    localparam int B2_OFS    = 762100;
    localparam int B3_SLOPE  = -45652;
    localparam int B3_OFS    = 2345600;
    localparam int B4_SLOPE  = -11500;
    localparam int B4_OFS    = 3017500;
    localparam int B5_SLOPE  = -22900;
    localparam int B5_OFS    = 4328500;

    function automatic logic [21:0] clamp_sum(input logic signed [23:0] s);
        if (s < 24'sd0) begin
            return 22'd0;
        end else if (s > 24'(CLAMP_TOP)) begin
            return 22'(CLAMP_TOP);
        end
        return 22'(s);
    endfunction

    logic signed [8:0]  cbo;
    logic signed [8:0]  cro;
    logic signed [23:0] cbo_w;
    logic signed [23:0] cro_w;
    logic signed [25:0] cb_w;
    logic signed [25:0] cr_w;

    // stage 1: constant products
    logic signed [23:0] r1_py;
    logic signed [23:0] r1_rcr;
    logic signed [23:0] r1_gcb;
    logic signed [23:0] r1_gcr;
    logic signed [23:0] r1_bcb;
    logic signed [25:0] r1_crs;
    logic signed [25:0] r1_bnd1;
    logic signed [25:0] r1_bnd2;
    logic signed [25:0] r1_bnd3;
    logic signed [25:0] r1_bnd4;
    logic signed [25:0] r1_bnd5;

    // stage 2: clamped sums and bound result
    logic [21:0]        r2_sr;
    logic [21:0]        r2_sg;
    logic [21:0]        r2_sb;
    logic               r2_chroma;

    // stage 3: reciprocal products
    logic [42:0]        r3_pr;
    logic [42:0]        r3_pg;
    logic [42:0]        r3_pb;
    logic               r3_chroma;

    assign cbo   = $signed({1'b0, i_pix.chroma_blue}) - 9'sd128;
    assign cro   = $signed({1'b0, i_pix.chroma_red}) - 9'sd128;
    assign cbo_w = 24'(cbo);
    assign cro_w = 24'(cro);
    assign cb_w  = 26'(i_pix.chroma_blue);
    assign cr_w  = 26'(i_pix.chroma_red);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_py   <= 24'(i_pix.luma) * 24'(K_Y);
            r1_rcr  <= cro_w * 24'(K_R_CR);
            r1_gcb  <= cbo_w * 24'(K_G_CB);
            r1_gcr  <= cro_w * 24'(K_G_CR);
            r1_bcb  <= cbo_w * 24'(K_B_CB);
            r1_crs  <= cr_w * 26'(K_CR);
            r1_bnd1 <= cb_w * 26'(B1_SLOPE) + 26'(B1_OFS);
            r1_bnd2 <= cb_w * 26'(B2_SLOPE) + 26'(B2_OFS);
            r1_bnd3 <= cb_w * 26'(B3_SLOPE) + 26'(B3_OFS);
            r1_bnd4 <= cb_w * 26'(B4_SLOPE) + 26'(B4_OFS);
            r1_bnd5 <= cb_w * 26'(B5_SLOPE) + 26'(B5_OFS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_sr     <= clamp_sum(r1_py + r1_rcr);
            r2_sg     <= clamp_sum(r1_py - r1_gcb - r1_gcr);
            r2_sb     <= clamp_sum(r1_py + r1_bcb);
            r2_chroma <= (r1_crs <= r1_bnd1) && (r1_crs >= r1_bnd2) &&
                         (r1_crs >= r1_bnd3) && (r1_crs <= r1_bnd4) &&
                         (r1_crs <= r1_bnd5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_pr     <= 43'(r2_sr) * 43'(RECIP);
            r3_pg     <= 43'(r2_sg) * 43'(RECIP);
            r3_pb     <= 43'(r2_sb) * 43'(RECIP);
            r3_chroma <= r2_chroma;
        end
    end

    assign o_rgb.r     = r3_pr[RECIP_SH +: 8];
    assign o_rgb.g     = r3_pg[RECIP_SH +: 8];
    assign o_rgb.b     = r3_pb[RECIP_SH +: 8];
    assign o_chroma_ok = r3_chroma;

endmodule

`default_nettype wire

### design/spc_prep.sv
// spc_prep: max/min, hue sector and numerator, RGB skin rules, one stage.
// Uses spc_pkg types; feeds the hue divider.
`default_nettype none

module spc_prep (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire spc_pkg::t_rgb                 i_rgb,
    input  wire logic                          i_chroma_ok,
    output logic [spc_pkg::NUM_W-1:0]          o_num,
    output logic [7:0]                         o_den,
    output spc_pkg::t_side                     o_side
);
    import spc_pkg::*;

    localparam logic [7:0] A_R_MIN   = 8'd95;
    localparam logic [7:0] A_G_MIN   = 8'd40;
    localparam logic [7:0] A_DEL_MIN = 8'd15;
    localparam logic [7:0] A_B_MIN   = 8'd20;
    localparam logic [7:0] RG_SPLIT  = 8'd15;
    localparam logic [7:0] B_R_MIN   = 8'd220;
    localparam logic [7:0] B_G_MIN   = 8'd210;
    localparam logic [7:0] B_B_MIN   = 8'd170;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] d;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        return d[8] ? 8'(-d) : 8'(d);
    endfunction

    logic [7:0]       mx;
    logic [7:0]       mn;
    logic [7:0]       del;
    logic [7:0]       drg;
    logic [7:0]       dsec;
    logic             rule_a;
    logic             rule_b;
    t_sector          sec;

    logic [NUM_W-1:0] r_num;
    logic [7:0]       r_den;
    t_side            r_side;

    always_comb begin
        if (i_rgb.r > i_rgb.g) begin
            mx = i_rgb.r;
            mn = i_rgb.g;
        end else begin
            mx = i_rgb.g;
            mn = i_rgb.r;
        end
        if (i_rgb.b > mx) begin
            mx = i_rgb.b;
        end
        if (i_rgb.b < mn) begin
            mn = i_rgb.b;
        end
        del = mx - mn;

        // red first on ties; grey lands in the red sector with a zero numerator
        if (i_rgb.r == mx) begin
            sec  = SEC_RED;
            dsec = abs_diff(i_rgb.g, i_rgb.b);
        end else if (i_rgb.g == mx) begin
            sec  = SEC_GREEN;
            dsec = abs_diff(i_rgb.b, i_rgb.r);
        end else begin
            sec  = SEC_BLUE;
            dsec = abs_diff(i_rgb.r, i_rgb.g);
        end

        drg    = abs_diff(i_rgb.r, i_rgb.g);
        rule_a = (i_rgb.r > A_R_MIN) && (i_rgb.g > A_G_MIN) && (del > A_DEL_MIN) &&
                 (i_rgb.b > A_B_MIN) && (drg > RG_SPLIT) && (i_rgb.r > i_rgb.g) &&
                 (i_rgb.r > i_rgb.b);
        rule_b = (i_rgb.r > B_R_MIN) && (i_rgb.g > B_G_MIN) && (i_rgb.b > B_B_MIN) &&
                 (drg <= RG_SPLIT) && (i_rgb.r > i_rgb.b) && (i_rgb.g > i_rgb.b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num           <= NUM_W'(dsec) * NUM_W'(HUE_SCALE);
            // keep the divisor nonzero so a grey pixel divides to zero
            r_den           <= (del == 8'd0) ? 8'd1 : del;
            r_side.rgb      <= i_rgb;
            r_side.sector   <= sec;
            r_side.pre_skin <= i_chroma_ok && (rule_a || rule_b);
        end
    end

    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

`default_nettype wire

### design/spc_div.sv
// spc_div: pipelined restoring divider for the hue fraction, one quotient bit per stage.
// Uses spc_pkg types; quotient never exceeds 60 since the numerator is below 64x the divisor.
`default_nettype none

module spc_div (
    input  wire logic                          i_clk,
    input  wire logic [spc_pkg::DIV_STG-1:0]   i_en,
    input  wire logic [spc_pkg::NUM_W-1:0]     i_num,
    input  wire logic [7:0]                    i_den,
    input  wire spc_pkg::t_side                i_side,
    output logic [spc_pkg::DIV_STG-1:0]        o_quo,
    output spc_pkg::t_side                     o_side
);
    import spc_pkg::*;

    logic [NUM_W-1:0]   r_rem  [DIV_STG-1];
    logic [7:0]         r_den  [DIV_STG-1];
    logic [DIV_STG-1:0] r_quo  [DIV_STG];
    t_side              r_side [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_step
        localparam int Sh = DIV_STG - 1 - s;

        logic [NUM_W-1:0]   rem_in;
        logic [7:0]         den_in;
        logic [DIV_STG-1:0] quo_in;
        t_side              side_in;
        logic [NUM_W:0]     trial;
        logic               take;

        if (s == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_rest
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign quo_in  = r_quo[s-1];
            assign side_in = r_side[s-1];
        end

        assign trial = (NUM_W+1)'(den_in) << Sh;
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_quo[s]  <= quo_in | (DIV_STG'(take) << Sh);
                r_side[s] <= side_in;
            end
        end

        // the last step needs no remainder or divisor downstream
        if (s < DIV_STG - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_rem[s] <= take ? NUM_W'({1'b0, rem_in} - trial) : rem_in;
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quo  = r_quo[DIV_STG-1];
    assign o_side = r_side[DIV_STG-1];

endmodule

`default_nettype wire
